// ===== sv/csramp_pkg.sv =====
// csramp_pkg: types, constants and codes shared by the current setpoint ramp
// depends on nothing; imported by every module of the block
`default_nettype none

package csramp_pkg;

    localparam int CURRENT_BITS    = 12;
    localparam int DEFAULT_CURRENT = 100;
    localparam int STEP_BITS       = 10;
    localparam int DELAY_BITS      = 16;
    localparam int WAIT_BITS       = DELAY_BITS + 1;
    localparam int CFG_IDX_BITS    = 1;
    localparam int CFG_DATA_BITS   = DELAY_BITS;

    typedef logic [CURRENT_BITS-1:0] t_cur;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_RX_REQ  = 2'd1,
        CMD_CHG_REQ = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_STEP  = 1'b0,
        CFG_DELAY = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0] cmd;
        t_cur       target_ma;
        t_cur       rx_limit_ma;
    } t_in_item;

    typedef struct packed {
        logic write_valid;
        t_cur write_ma;
        t_cur present_ma;
        logic busy_res;
    } t_out_item;

    typedef struct packed {
        logic [STEP_BITS-1:0]  step_ma;
        logic [DELAY_BITS-1:0] delay_ticks;
    } t_cfg;

    typedef struct packed {
        t_cur                 present;
        t_cur                 charger_limit;
        t_cur                 ramp_target;
        t_cur                 next_write;
        logic [WAIT_BITS-1:0] wait_count;
        logic                 active;
    } t_state;

    localparam t_state STATE_RESET = '{
        present:       CURRENT_BITS'(DEFAULT_CURRENT),
        charger_limit: '0,
        ramp_target:   '0,
        next_write:    '0,
        wait_count:    '0,
        active:        1'b0
    };

endpackage

`default_nettype wire

// ===== sv/csramp_cfg.sv =====
// csramp_cfg: step and delay configuration registers
// depends on csramp_pkg
`default_nettype none

module csramp_cfg (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [csramp_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire  [csramp_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output csramp_pkg::t_cfg                    o_cfg
);
    import csramp_pkg::*;

    logic [STEP_BITS-1:0]  r_step;
    logic [DELAY_BITS-1:0] r_delay;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_delay <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_STEP:  r_step  <= i_cfg_data[STEP_BITS-1:0];
                CFG_DELAY: r_delay <= i_cfg_data[DELAY_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.step_ma     = r_step;
    assign o_cfg.delay_ticks = r_delay;

endmodule

`default_nettype wire

// ===== sv/csramp_step.sv =====
// csramp_step: single-pass next-state and result logic for one item
// depends on csramp_pkg
`default_nettype none

module csramp_step (
    input  csramp_pkg::t_in_item  i_item,
    input  csramp_pkg::t_cfg      i_cfg,
    input  csramp_pkg::t_state    i_state,
    output csramp_pkg::t_state    o_state,
    output csramp_pkg::t_out_item o_result
);
    import csramp_pkg::*;

    t_cur                 req_t;
    logic                 is_req;
    logic                 req_ok;
    logic                 do_wr;
    t_cur                 wr_w;
    t_cur                 wr_t;
    t_cur                 up_diff;
    t_cur                 dn_diff;
    t_cur                 step_ext;
    logic                 cfg_off;
    t_state               s;

    assign step_ext = CURRENT_BITS'(i_cfg.step_ma);
    assign cfg_off  = (i_cfg.step_ma == '0) || (i_cfg.delay_ticks == '0);

    always_comb begin
        s       = i_state;
        is_req  = 1'b0;
        req_t   = '0;
        do_wr   = 1'b0;
        wr_w    = i_state.next_write;
        wr_t    = i_state.ramp_target;

        case (t_cmd'(i_item.cmd))
            CMD_RX_REQ: begin
                is_req = 1'b1;
                // clamp to charger limit only when one is stored
                if (i_state.charger_limit != '0 &&
                        i_item.target_ma > i_state.charger_limit) begin
                    req_t = i_state.charger_limit;
                end else begin
                    req_t = i_item.target_ma;
                end
            end
            CMD_CHG_REQ: begin
                is_req          = 1'b1;
                s.charger_limit = i_item.target_ma;
                req_t = (i_item.target_ma < i_item.rx_limit_ma) ?
                        i_item.target_ma : i_item.rx_limit_ma;
            end
            default: begin
                if (i_state.active) begin
                    if (i_state.wait_count > WAIT_BITS'(1)) begin
                        s.wait_count = i_state.wait_count - WAIT_BITS'(1);
                    end else begin
                        s.wait_count = '0;
                        do_wr        = 1'b1;
                    end
                end
            end
        endcase

        req_ok = is_req && (req_t != '0) && !cfg_off;
        if (req_ok) begin
            s.ramp_target = req_t;
            s.next_write  = i_state.present;
            if (i_state.active) begin
                // restart with a pre-wait of twice the delay
                s.wait_count = {i_cfg.delay_ticks, 1'b0};
            end else begin
                s.active = 1'b1;
                do_wr    = 1'b1;
                wr_w     = i_state.present;
                wr_t     = req_t;
            end
        end

        up_diff = wr_t - wr_w;
        dn_diff = wr_w - wr_t;
        if (do_wr) begin
            s.present = wr_w;
            if (wr_w == wr_t) begin
                s.active     = 1'b0;
                s.wait_count = '0;
                s.next_write = wr_w;
            end else begin
                if (cfg_off) begin
                    s.next_write = wr_t;
                end else if (wr_t > wr_w) begin
                    s.next_write = (up_diff > step_ext) ? wr_w + step_ext : wr_t;
                end else begin
                    s.next_write = (dn_diff > step_ext) ? wr_w - step_ext : wr_t;
                end
                s.wait_count = WAIT_BITS'(i_cfg.delay_ticks);
            end
        end

        o_state              = s;
        o_result.write_valid = do_wr;
        o_result.write_ma    = do_wr ? wr_w : '0;
        o_result.present_ma  = s.present;
        o_result.busy_res    = s.active;
    end

endmodule

`default_nettype wire

// ===== sv/current_setpoint_ramp.sv =====
// Slew-rate limited input-current setpoint ramp. Each accepted item (a tick,
// a receiver request or a charger request) yields exactly one result item via
// the input register and then the result register; an item can be accepted
// in every cycle unless the output side is stalled, the rate being set by one
// pass of the step logic between the input register and the result register,
// with the ramp state updated as each item passes. Configuration writes are
// taken in any cycle and should only be issued while the block is idle.
// depends on csramp_pkg, csramp_cfg, csramp_step
`default_nettype none

module current_setpoint_ramp (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  csramp_pkg::t_in_item                i_in_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output csramp_pkg::t_out_item               o_out_data,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [csramp_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire  [csramp_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import csramp_pkg::*;

    t_cfg      cfg;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_state    r_state;
    t_state    n_state;
    t_out_item n_out_item;
    logic      advance;

    csramp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    csramp_step u_step (
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out_item)
    );

    // item moves from input register to result register
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

`default_nettype wire
